[design/sts_pkg.sv]
// Shared token kinds, scanner mode codes and operator helpers for the token scanner.
package sts_pkg;

    localparam logic [5:0] K_LPAREN   = 6'd0;
    localparam logic [5:0] K_RPAREN   = 6'd1;
    localparam logic [5:0] K_LBRACE   = 6'd2;
    localparam logic [5:0] K_RBRACE   = 6'd3;
    localparam logic [5:0] K_LBRACK   = 6'd4;
    localparam logic [5:0] K_RBRACK   = 6'd5;
    localparam logic [5:0] K_SEMI     = 6'd6;
    localparam logic [5:0] K_COLON    = 6'd7;
    localparam logic [5:0] K_COMMA    = 6'd8;
    localparam logic [5:0] K_DOT      = 6'd9;
    localparam logic [5:0] K_MINUS    = 6'd10;
    localparam logic [5:0] K_PLUS     = 6'd11;
    localparam logic [5:0] K_SLASH    = 6'd12;
    localparam logic [5:0] K_STAR     = 6'd13;
    localparam logic [5:0] K_CARET    = 6'd14;
    localparam logic [5:0] K_BSLASH   = 6'd15;
    localparam logic [5:0] K_BANG     = 6'd16;
    localparam logic [5:0] K_BANG_EQ  = 6'd17;
    localparam logic [5:0] K_EQ       = 6'd18;
    localparam logic [5:0] K_EQ_EQ    = 6'd19;
    localparam logic [5:0] K_ARROW    = 6'd20;
    localparam logic [5:0] K_LESS     = 6'd21;
    localparam logic [5:0] K_LESS_EQ  = 6'd22;
    localparam logic [5:0] K_GREAT    = 6'd23;
    localparam logic [5:0] K_GREAT_EQ = 6'd24;
    localparam logic [5:0] K_TILDE    = 6'd25;
    localparam logic [5:0] K_TILDE_EQ = 6'd26;
    localparam logic [5:0] K_ELLIPSIS = 6'd27;
    localparam logic [5:0] K_STRING   = 6'd28;
    localparam logic [5:0] K_NUMBER   = 6'd29;
    localparam logic [5:0] K_IMAG     = 6'd30;
    localparam logic [5:0] K_IDENT    = 6'd31;
    localparam logic [5:0] K_KW0      = 6'd32;
    localparam logic [5:0] K_EOF      = 6'd55;
    localparam logic [5:0] K_REPL_EOF = 6'd56;
    localparam logic [5:0] K_ERROR    = 6'd57;

    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_UNEXP    = 2'd1;
    localparam logic [1:0] E_UNTERM   = 2'd2;

    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_SLASH    = 4'd1;
    localparam logic [3:0] M_COMMENT  = 4'd2;
    localparam logic [3:0] M_WORD     = 4'd3;
    localparam logic [3:0] M_INT      = 4'd4;
    localparam logic [3:0] M_NUMDOT   = 4'd5;
    localparam logic [3:0] M_FRAC     = 4'd6;
    localparam logic [3:0] M_STR      = 4'd7;
    localparam logic [3:0] M_OP2      = 4'd8;
    localparam logic [3:0] M_DOT1     = 4'd9;
    localparam logic [3:0] M_DOT2     = 4'd10;

    localparam int KW_COUNT = 23;

    // keyword text left-justified, first character in the top byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        {"and", 40'd0}, {"class", 24'd0}, {"else", 32'd0}, {"false", 24'd0},
        {"fail", 32'd0}, {"for", 40'd0}, {"fun", 40'd0}, {"if", 48'd0},
        {"nil", 40'd0}, {"or", 48'd0}, {"print", 24'd0}, {"return", 16'd0},
        {"super", 24'd0}, {"static", 16'd0}, {"this", 32'd0}, {"true", 32'd0},
        {"var", 40'd0}, {"while", 24'd0}, {"break", 24'd0}, {"continue"},
        {"extend", 16'd0}, {"range", 24'd0}, {"assert", 16'd0}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd4, 4'd5, 4'd4, 4'd3, 4'd3, 4'd2, 4'd3, 4'd2, 4'd5, 4'd6,
        4'd5, 4'd6, 4'd4, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8, 4'd6, 4'd5, 4'd6
    };

    function automatic logic [5:0] op_single(input logic [7:0] p);
        case (p)
            "!":     return K_BANG;
            "=":     return K_EQ;
            "<":     return K_LESS;
            ">":     return K_GREAT;
            default: return K_TILDE;
        endcase
    endfunction

    function automatic logic [5:0] op_with_eq(input logic [7:0] p);
        case (p)
            "!":     return K_BANG_EQ;
            "=":     return K_EQ_EQ;
            "<":     return K_LESS_EQ;
            ">":     return K_GREAT_EQ;
            default: return K_TILDE_EQ;
        endcase
    endfunction

endpackage

[design/script_token_scanner_core.sv]
// Top level of the streaming script token scanner.
// One source byte (or an end marker) is taken per request and scanned in the same cycle;
// its tokens (zero to three) land in a result register and leave one per cycle while the
// receiver does not stall. A request yielding at most one token lets the next one enter in
// the following cycle, so plain text runs at one byte per clock, if the receiver does not
// stall; two or three tokens hold the input while the register drains. No clearing pass.
module script_token_scanner_core #(
    parameter int OFFSET_BITS = 16,
    parameter int LINE_BITS   = 16,
    parameter int WORD_BYTES  = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_in_byte,
    input  logic                   i_is_end,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [5:0]             o_token_kind,
    output logic [OFFSET_BITS-1:0] o_token_start,
    output logic [OFFSET_BITS-1:0] o_token_length,
    output logic [LINE_BITS-1:0]   o_token_line,
    output logic [1:0]             o_error_code,
    output logic                   o_last_of_run
);
    localparam int W = 9 + 2 * OFFSET_BITS + LINE_BITS;

    logic         ready, acc;
    logic [1:0]   cnt;
    logic [W-1:0] res [3];
    logic [W-1:0] q;

    assign o_stall = !ready;
    assign acc     = i_valid && ready;

    sts_lexer #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .WORD_BYTES  (WORD_BYTES),
        .W           (W)
    ) u_lexer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_byte     (i_in_byte),
        .i_end      (i_is_end),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_cnt      (cnt),
        .o_res      (res)
    );

    sts_out_queue #(.W(W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (acc),
        .i_cnt   (cnt),
        .i_res   (res),
        .i_pop   (!i_stall),
        .o_ready (ready),
        .o_valid (o_valid),
        .o_data  (q)
    );

    assign o_token_kind   = q[W-1 -: 6];
    assign o_token_start  = q[W-7 -: OFFSET_BITS];
    assign o_token_length = q[W-7-OFFSET_BITS -: OFFSET_BITS];
    assign o_token_line   = q[LINE_BITS+2 : 3];
    assign o_error_code   = q[2:1];
    assign o_last_of_run  = q[0];

endmodule

[design/sts_kw_match.sv]
// Parallel keyword compare of the identifier buffer against the keyword table.
module sts_kw_match (
    input  logic [63:0] i_word,
    input  logic [3:0]  i_len,
    input  logic        i_len_ok,
    output logic [5:0]  o_kind
);
    import sts_pkg::*;

    logic [63:0] mask;

    always_comb begin
        mask   = ~(64'hFFFF_FFFF_FFFF_FFFF >> ({3'd0, i_len} * 7'd8));
        o_kind = K_IDENT;
        if (i_len_ok) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (KW_LEN[k] == i_len && (i_word & mask) == KW_TEXT[k]) begin
                    o_kind = K_KW0 + 6'(k);
                end
            end
        end
    end

endmodule

[design/sts_lexer.sv]
// Scanner state and the per-request transition that produces up to three tokens.
module sts_lexer #(
    parameter int OFFSET_BITS = 16,
    parameter int LINE_BITS   = 16,
    parameter int WORD_BYTES  = 8,
    parameter int W           = 9 + 2 * OFFSET_BITS + LINE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_acc,
    input  logic [7:0]   i_byte,
    input  logic         i_end,
    input  logic         i_cfg_we,
    input  logic         i_cfg_data,
    output logic [1:0]   o_cnt,
    output logic [W-1:0] o_res [3]
);
    import sts_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int LB = LINE_BITS;
    localparam int WL = $clog2(WORD_BYTES + 2);
    localparam int IW = $clog2(WORD_BYTES);

    logic [3:0]    r_mode, md;
    logic [7:0]    r_pend, pend;
    logic [7:0]    r_buf [WORD_BYTES];
    logic [WL-1:0] r_wlen, wlen;
    logic [OB-1:0] r_ls, ls, r_ofs, r_llen, ll, r_dot, dot;
    logic [LB-1:0] r_line, line, r_lline, lline;
    logic          r_repl;

    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [63:0]   pk;
    logic [5:0]    kw_kind, word_kind;
    logic          done;
    logic [1:0]    nr;
    logic [W-1:0]  res [3];
    logic [7:0]    c;
    logic          is_alpha, is_digit;

    function automatic logic [OB-1:0] sat_o(input logic [OB-1:0] v, input logic [1:0] d);
        logic [OB:0] s;
        s = {1'b0, v} + {{(OB - 1){1'b0}}, d};
        return s[OB] ? {OB{1'b1}} : s[OB-1:0];
    endfunction

    function automatic logic [LB-1:0] sat_l(input logic [LB-1:0] v);
        return (&v) ? v : v + LB'(1);
    endfunction

    function automatic logic [W-1:0] rec(input logic [5:0] k, input logic [OB-1:0] s,
                                         input logic [OB-1:0] l, input logic [LB-1:0] n,
                                         input logic [1:0] e);
        return {k, s, l, n, e, 1'b0};
    endfunction

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            pk[63 - 8 * i -: 8] = r_buf[i];
        end
    end

    sts_kw_match u_kw (
        .i_word   (pk),
        .i_len    (r_wlen[3:0]),
        .i_len_ok (r_wlen <= WL'(8)),
        .o_kind   (kw_kind)
    );

    assign word_kind = (r_wlen > WL'(WORD_BYTES)) ? K_IDENT : kw_kind;
    assign c         = i_byte;
    assign is_alpha  = c inside {["a":"z"], ["A":"Z"], "_", "'"};
    assign is_digit  = c inside {["0":"9"]};

    always_comb begin
        md = r_mode; pend = r_pend; wlen = r_wlen; ls = r_ls; ll = r_llen;
        dot = r_dot; line = r_line; lline = r_lline;
        wr_en = 1'b0; wr_idx = '0; done = 1'b0; nr = '0;
        for (int j = 0; j < 3; j++) begin
            res[j] = '0;
        end
        if (i_end) begin
            case (md)
                M_SLASH: begin res[nr] = rec(K_SLASH, ls, OB'(1), lline, E_NONE); nr++; end
                M_WORD:  begin res[nr] = rec(word_kind, ls, ll, lline, E_NONE); nr++; end
                M_INT, M_FRAC: begin
                    res[nr] = rec(K_NUMBER, ls, ll, lline, E_NONE); nr++;
                end
                M_NUMDOT: begin
                    res[nr] = rec(K_NUMBER, ls, ll, lline, E_NONE); nr++;
                    res[nr] = rec(K_DOT, dot, OB'(1), line, E_NONE); nr++;
                end
                M_OP2: begin
                    res[nr] = rec(op_single(pend), ls, OB'(1), lline, E_NONE); nr++;
                end
                M_DOT1: begin res[nr] = rec(K_DOT, ls, OB'(1), lline, E_NONE); nr++; end
                M_DOT2: begin res[nr] = rec(K_DOT, ls, OB'(2), lline, E_NONE); nr++; end
                M_STR:  begin res[nr] = rec(K_ERROR, ls, ll, lline, E_UNTERM); nr++; end
                default: ;
            endcase
            md = M_IDLE;
            res[nr] = rec(r_repl ? K_REPL_EOF : K_EOF, r_ofs, '0, line, E_NONE);
            nr++;
        end else begin
            // a byte that ends a token is handed again to the next mode
            for (int it = 0; it < 3; it++) begin
                if (!done) begin
                    done = 1'b1;
                    case (md)
                        M_SLASH: begin
                            if (c == "/") md = M_COMMENT;
                            else begin
                                res[nr] = rec(K_SLASH, ls, OB'(1), lline, E_NONE); nr++;
                                md = M_IDLE; done = 1'b0;
                            end
                        end
                        M_COMMENT: begin
                            if (c == "\n") begin md = M_IDLE; done = 1'b0; end
                        end
                        M_WORD: begin
                            if (is_alpha || is_digit) begin
                                if (wlen < WL'(WORD_BYTES)) begin
                                    wr_en = 1'b1; wr_idx = wlen[IW-1:0];
                                end
                                if (wlen <= WL'(WORD_BYTES)) wlen = wlen + WL'(1);
                                ll = sat_o(ll, 2'd1);
                            end else begin
                                res[nr] = rec(word_kind, ls, ll, lline, E_NONE); nr++;
                                md = M_IDLE; done = 1'b0;
                            end
                        end
                        M_INT, M_FRAC: begin
                            if (is_digit) ll = sat_o(ll, 2'd1);
                            else if (c == "." && md == M_INT) begin
                                dot = r_ofs; md = M_NUMDOT;
                            end else if (c == "i") begin
                                res[nr] = rec(K_IMAG, ls, sat_o(ll, 2'd1), lline, E_NONE);
                                nr++; md = M_IDLE;
                            end else begin
                                res[nr] = rec(K_NUMBER, ls, ll, lline, E_NONE); nr++;
                                md = M_IDLE; done = 1'b0;
                            end
                        end
                        M_NUMDOT: begin
                            if (is_digit) begin
                                ll = sat_o(ll, 2'd2); md = M_FRAC;
                            end else begin
                                res[nr] = rec(K_NUMBER, ls, ll, lline, E_NONE); nr++;
                                ls = dot; lline = line; ll = OB'(1);
                                md = M_DOT1; done = 1'b0;
                            end
                        end
                        M_STR: begin
                            ll = sat_o(ll, 2'd1);
                            if (c == "\"") begin
                                res[nr] = rec(K_STRING, ls, ll, lline, E_NONE); nr++;
                                md = M_IDLE;
                            end else if (c == "\n") line = sat_l(line);
                        end
                        M_OP2: begin
                            if (c == "=") begin
                                res[nr] = rec(op_with_eq(pend), ls, OB'(2), lline, E_NONE);
                                nr++; md = M_IDLE;
                            end else if (c == ">" && pend == "=") begin
                                res[nr] = rec(K_ARROW, ls, OB'(2), lline, E_NONE);
                                nr++; md = M_IDLE;
                            end else begin
                                res[nr] = rec(op_single(pend), ls, OB'(1), lline, E_NONE);
                                nr++; md = M_IDLE; done = 1'b0;
                            end
                        end
                        M_DOT1: begin
                            if (c == ".") begin ll = OB'(2); md = M_DOT2; end
                            else begin
                                res[nr] = rec(K_DOT, ls, OB'(1), lline, E_NONE); nr++;
                                md = M_IDLE; done = 1'b0;
                            end
                        end
                        M_DOT2: begin
                            if (c == ".") begin
                                res[nr] = rec(K_ELLIPSIS, ls, OB'(3), lline, E_NONE);
                                nr++; md = M_IDLE;
                            end else begin
                                res[nr] = rec(K_DOT, ls, OB'(2), lline, E_NONE); nr++;
                                md = M_IDLE; done = 1'b0;
                            end
                        end
                        default: begin
                            md = M_IDLE;
                            if (c == " " || c == "\r" || c == "\t") ;
                            else if (c == "\n") line = sat_l(line);
                            else begin
                                ls = r_ofs; lline = line; ll = OB'(1);
                                if (is_alpha) begin
                                    md = M_WORD; wr_en = 1'b1; wr_idx = '0; wlen = WL'(1);
                                end else if (is_digit) md = M_INT;
                                else begin
                                    case (c)
                                        "(": begin res[nr] = rec(K_LPAREN, ls, ll, lline, E_NONE); nr++; end
                                        ")": begin res[nr] = rec(K_RPAREN, ls, ll, lline, E_NONE); nr++; end
                                        "{": begin res[nr] = rec(K_LBRACE, ls, ll, lline, E_NONE); nr++; end
                                        "}": begin res[nr] = rec(K_RBRACE, ls, ll, lline, E_NONE); nr++; end
                                        "[": begin res[nr] = rec(K_LBRACK, ls, ll, lline, E_NONE); nr++; end
                                        "]": begin res[nr] = rec(K_RBRACK, ls, ll, lline, E_NONE); nr++; end
                                        ";": begin res[nr] = rec(K_SEMI, ls, ll, lline, E_NONE); nr++; end
                                        ":": begin res[nr] = rec(K_COLON, ls, ll, lline, E_NONE); nr++; end
                                        ",": begin res[nr] = rec(K_COMMA, ls, ll, lline, E_NONE); nr++; end
                                        "-": begin res[nr] = rec(K_MINUS, ls, ll, lline, E_NONE); nr++; end
                                        "+": begin res[nr] = rec(K_PLUS, ls, ll, lline, E_NONE); nr++; end
                                        "*": begin res[nr] = rec(K_STAR, ls, ll, lline, E_NONE); nr++; end
                                        "^": begin res[nr] = rec(K_CARET, ls, ll, lline, E_NONE); nr++; end
                                        "\\": begin res[nr] = rec(K_BSLASH, ls, ll, lline, E_NONE); nr++; end
                                        "/": md = M_SLASH;
                                        ".": md = M_DOT1;
                                        "\"": md = M_STR;
                                        "!", "=", "<", ">", "~": begin pend = c; md = M_OP2; end
                                        default: begin
                                            res[nr] = rec(K_ERROR, ls, ll, lline, E_UNEXP); nr++;
                                        end
                                    endcase
                                end
                            end
                        end
                    endcase
                end
            end
        end
        // mark the final token of this request
        if (nr != 2'd0) res[nr - 2'd1][0] = 1'b1;
    end

    assign o_cnt = nr;
    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pend  <= '0;
            r_wlen  <= '0;
            r_ls    <= '0;
            r_ofs   <= '0;
            r_llen  <= '0;
            r_dot   <= '0;
            r_line  <= LB'(1);
            r_lline <= LB'(1);
            r_repl  <= 1'b0;
        end else begin
            if (i_cfg_we) r_repl <= i_cfg_data;
            if (i_acc) begin
                r_mode  <= md;
                r_pend  <= pend;
                r_wlen  <= wlen;
                r_ls    <= ls;
                r_llen  <= ll;
                r_dot   <= dot;
                r_line  <= line;
                r_lline <= lline;
                if (!i_end) r_ofs <= sat_o(r_ofs, 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && !i_end && wr_en) r_buf[wr_idx] <= c;
    end

endmodule

[design/sts_out_queue.sv]
// Result register holding the up to three tokens of one request, drained in order.
module sts_out_queue #(
    parameter int W = 57
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  logic [1:0]   i_cnt,
    input  logic [W-1:0] i_res [3],
    input  logic         i_pop,
    output logic         o_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_data [3];
    logic [1:0]   r_cnt, r_head;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_data[r_head];
    // take a new request when empty or once the last held token leaves this cycle
    assign o_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_head <= '0;
        end else if (i_load) begin
            r_cnt  <= i_cnt;
            r_head <= '0;
        end else if (i_pop && o_valid) begin
            r_cnt  <= r_cnt - 2'd1;
            r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_data <= i_res;
    end

endmodule

[bench/token_scan_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the token scanner: predicts tokens from accepted requests and compares them.
module token_scan_checker
    import sts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_in_byte,
    input  logic        i_is_end,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [5:0]  i_kind,
    input  logic [15:0] i_start,
    input  logic [15:0] i_length,
    input  logic [15:0] i_line,
    input  logic [1:0]  i_err,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_accepts
);

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic [1:0]  err;
        logic        last;
    } token_t;

    token_t      token_q[$];
    token_t      run_q[$];
    logic        repl;
    logic [3:0]  mode;
    logic [7:0]  op_char;
    logic [7:0]  word_buf[8];
    int          word_len;
    logic [15:0] lex_start, offset, line_no, lex_line, lex_len, dot_ofs;

    function automatic logic [15:0] sat16(input logic [15:0] v, input int d);
        int s;
        s = int'(v) + d;
        return (s > 65535) ? 16'hFFFF : 16'(s);
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == 8'h27;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic emit(input logic [5:0] k, input logic [15:0] s, input logic [15:0] l,
                        input logic [15:0] ln, input logic [1:0] e);
        token_t t;
        t = '{kind: k, start: s, length: l, line: ln, err: e, last: 1'b0};
        if (run_q.size() < 3) run_q.push_back(t);
    endtask

    function automatic logic [5:0] keyword_of();
        logic [63:0] txt;
        if (word_len > 8) return K_IDENT;
        txt = '0;
        for (int i = 0; i < word_len; i++) txt[63-8*i -: 8] = word_buf[i];
        for (int k = 0; k < KW_COUNT; k++)
            if (int'(KW_LEN[k]) == word_len && KW_TEXT[k] == txt) return K_KW0 + 6'(k);
        return K_IDENT;
    endfunction

    function automatic logic [5:0] single_op(input logic [7:0] p);
        case (p)
            "!": return K_BANG;
            "=": return K_EQ;
            "<": return K_LESS;
            ">": return K_GREAT;
            default: return K_TILDE;
        endcase
    endfunction

    function automatic logic [5:0] eq_op(input logic [7:0] p);
        case (p)
            "!": return K_BANG_EQ;
            "=": return K_EQ_EQ;
            "<": return K_LESS_EQ;
            ">": return K_GREAT_EQ;
            default: return K_TILDE_EQ;
        endcase
    endfunction

    task automatic begin_lexeme(input logic [15:0] cur, input logic [3:0] m);
        lex_start = cur;
        lex_line = line_no;
        lex_len = 1;
        mode = m;
    endtask

    // returns 1 when the byte is consumed, 0 to rescan it in the new mode
    task automatic scan_byte(input logic [7:0] c, input logic [15:0] cur, output bit done);
        done = 1;
        case (mode)
            M_SLASH: begin
                if (c == "/") begin mode = M_COMMENT; return; end
                emit(K_SLASH, lex_start, 1, lex_line, E_NONE);
                mode = M_IDLE; done = 0; return;
            end
            M_COMMENT: begin
                if (c == 8'h0A) begin mode = M_IDLE; done = 0; end
                return;
            end
            M_WORD: begin
                if (is_alpha(c) || is_digit(c)) begin
                    if (word_len < 8) word_buf[word_len] = c;
                    if (word_len <= 8) word_len++;
                    lex_len = sat16(lex_len, 1);
                    return;
                end
                emit(keyword_of(), lex_start, lex_len, lex_line, E_NONE);
                mode = M_IDLE; done = 0; return;
            end
            M_INT, M_FRAC: begin
                if (is_digit(c)) begin lex_len = sat16(lex_len, 1); return; end
                if (c == "." && mode == M_INT) begin dot_ofs = cur; mode = M_NUMDOT; return; end
                if (c == "i") begin
                    emit(K_IMAG, lex_start, sat16(lex_len, 1), lex_line, E_NONE);
                    mode = M_IDLE; return;
                end
                emit(K_NUMBER, lex_start, lex_len, lex_line, E_NONE);
                mode = M_IDLE; done = 0; return;
            end
            M_NUMDOT: begin
                if (is_digit(c)) begin lex_len = sat16(lex_len, 2); mode = M_FRAC; return; end
                emit(K_NUMBER, lex_start, lex_len, lex_line, E_NONE);
                lex_start = dot_ofs; lex_line = line_no; lex_len = 1;
                mode = M_DOT1; done = 0; return;
            end
            M_STR: begin
                lex_len = sat16(lex_len, 1);
                if (c == 8'h22) begin
                    emit(K_STRING, lex_start, lex_len, lex_line, E_NONE);
                    mode = M_IDLE;
                end else if (c == 8'h0A) begin
                    line_no = sat16(line_no, 1);
                end
                return;
            end
            M_OP2: begin
                if (c == "=") begin
                    emit(eq_op(op_char), lex_start, 2, lex_line, E_NONE);
                    mode = M_IDLE; return;
                end
                if (c == ">" && op_char == "=") begin
                    emit(K_ARROW, lex_start, 2, lex_line, E_NONE);
                    mode = M_IDLE; return;
                end
                emit(single_op(op_char), lex_start, 1, lex_line, E_NONE);
                mode = M_IDLE; done = 0; return;
            end
            M_DOT1: begin
                if (c == ".") begin lex_len = 2; mode = M_DOT2; return; end
                emit(K_DOT, lex_start, 1, lex_line, E_NONE);
                mode = M_IDLE; done = 0; return;
            end
            M_DOT2: begin
                if (c == ".") begin
                    emit(K_ELLIPSIS, lex_start, 3, lex_line, E_NONE);
                    mode = M_IDLE; return;
                end
                emit(K_DOT, lex_start, 2, lex_line, E_NONE);
                mode = M_IDLE; done = 0; return;
            end
            default: ;
        endcase
        mode = M_IDLE;
        if (c == " " || c == 8'h0D || c == 8'h09) return;
        if (c == 8'h0A) begin line_no = sat16(line_no, 1); return; end
        if (is_alpha(c)) begin
            begin_lexeme(cur, M_WORD);
            word_buf[0] = c;
            word_len = 1;
            return;
        end
        if (is_digit(c)) begin begin_lexeme(cur, M_INT); return; end
        begin_lexeme(cur, M_IDLE);
        case (c)
            "(": emit(K_LPAREN, lex_start, 1, lex_line, E_NONE);
            ")": emit(K_RPAREN, lex_start, 1, lex_line, E_NONE);
            "{": emit(K_LBRACE, lex_start, 1, lex_line, E_NONE);
            "}": emit(K_RBRACE, lex_start, 1, lex_line, E_NONE);
            "[": emit(K_LBRACK, lex_start, 1, lex_line, E_NONE);
            "]": emit(K_RBRACK, lex_start, 1, lex_line, E_NONE);
            ";": emit(K_SEMI, lex_start, 1, lex_line, E_NONE);
            ":": emit(K_COLON, lex_start, 1, lex_line, E_NONE);
            ",": emit(K_COMMA, lex_start, 1, lex_line, E_NONE);
            "-": emit(K_MINUS, lex_start, 1, lex_line, E_NONE);
            "+": emit(K_PLUS, lex_start, 1, lex_line, E_NONE);
            "*": emit(K_STAR, lex_start, 1, lex_line, E_NONE);
            "^": emit(K_CARET, lex_start, 1, lex_line, E_NONE);
            8'h5C: emit(K_BSLASH, lex_start, 1, lex_line, E_NONE);
            "/": mode = M_SLASH;
            ".": mode = M_DOT1;
            8'h22: mode = M_STR;
            "!", "=", "<", ">", "~": begin op_char = c; mode = M_OP2; end
            default: emit(K_ERROR, lex_start, 1, lex_line, E_UNEXP);
        endcase
    endtask

    task automatic predict(input logic [7:0] c, input logic fin);
        bit done;
        int guard;
        run_q.delete();
        if (fin) begin
            case (mode)
                M_SLASH: emit(K_SLASH, lex_start, 1, lex_line, E_NONE);
                M_WORD: emit(keyword_of(), lex_start, lex_len, lex_line, E_NONE);
                M_INT, M_FRAC: emit(K_NUMBER, lex_start, lex_len, lex_line, E_NONE);
                M_NUMDOT: begin
                    emit(K_NUMBER, lex_start, lex_len, lex_line, E_NONE);
                    emit(K_DOT, dot_ofs, 1, line_no, E_NONE);
                end
                M_OP2: emit(single_op(op_char), lex_start, 1, lex_line, E_NONE);
                M_DOT1: emit(K_DOT, lex_start, 1, lex_line, E_NONE);
                M_DOT2: emit(K_DOT, lex_start, 2, lex_line, E_NONE);
                M_STR: emit(K_ERROR, lex_start, lex_len, lex_line, E_UNTERM);
                default: ;
            endcase
            mode = M_IDLE;
            emit(repl ? K_REPL_EOF : K_EOF, offset, 0, line_no, E_NONE);
        end else begin
            guard = 0;
            scan_byte(c, offset, done);
            while (!done && guard < 4) begin
                guard++;
                scan_byte(c, offset, done);
            end
            offset = sat16(offset, 1);
        end
        if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
        foreach (run_q[i]) token_q.push_back(run_q[i]);
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_accepts = 0;
    end

    assign o_pending = token_q.size();

    always @(posedge i_clk) begin
        token_t want;
        if (!i_rst_n) begin
            repl = 0; mode = M_IDLE; op_char = 0; word_len = 0;
            lex_start = 0; offset = 0; line_no = 1; lex_line = 1; lex_len = 0; dot_ofs = 0;
            token_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (token_q.size() == 0) begin
                    report("unexpected token kind", 16'(i_kind), 16'hFFFF);
                end else begin
                    want = token_q.pop_front();
                    if (i_kind != want.kind) report("kind", 16'(i_kind), 16'(want.kind));
                    if (i_start != want.start) report("start", i_start, want.start);
                    if (i_length != want.length) report("length", i_length, want.length);
                    if (i_line != want.line) report("line", i_line, want.line);
                    if (i_err != want.err) report("error", 16'(i_err), 16'(want.err));
                    if (i_last != want.last) report("last", 16'(i_last), 16'(want.last));
                end
            end
            if (i_cfg_we) repl = i_cfg_data;
            if (i_valid && !i_stall_in) begin
                predict(i_in_byte, i_is_end);
                o_accepts++;
            end
        end
    end

endmodule

[bench/tb_script_token_scanner_core.sv]
`timescale 1ns / 1ps
// Top of the token scanner bench: clock, reset, source stimulus, output stalls and verdict.
module tb_script_token_scanner_core;
    import sts_pkg::*;

    logic        clk, rst_n;
    logic        in_valid, in_stall;
    logic [7:0]  in_byte;
    logic        is_end;
    logic        cfg_we, cfg_data;
    logic        out_valid, out_stall;
    logic [5:0]  tok_kind;
    logic [15:0] tok_start, tok_length, tok_line;
    logic [1:0]  tok_err;
    logic        tok_last;
    int          fail_count, pending, accepts;
    int          idle_cycles;
    bit          hold_off, stall_busy;

    string words[] = '{"and", "class", "else", "false", "fail", "for", "fun", "if", "nil",
        "or", "print", "return", "super", "static", "this", "true", "var", "while",
        "break", "continue", "extend", "range", "assert", "x_1", "it's", "continued",
        "Foo", "classy", "an", "breakage_long_name"};
    string snippets[] = '{"(", ")", "{", "}", "[", "]", ";", ":", ",", ".", "-", "+", "/",
        "*", "^", "\\", "!", "!=", "=", "==", "=>", "<", "<=", ">", ">=", "~", "~=",
        "...", "..", "12", "3.25", "7i", "4.5i", "9.", "9.x", "\"hi there\"",
        "\"a\nb\"", "// note\n", " ", "\n", "\t", "\r", "@", "#", "a.b"};

    script_token_scanner_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_in_byte(in_byte), .i_is_end(is_end),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_token_kind(tok_kind), .o_token_start(tok_start), .o_token_length(tok_length),
        .o_token_line(tok_line), .o_error_code(tok_err), .o_last_of_run(tok_last)
    );

    token_scan_checker u_check (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_in_byte(in_byte), .i_is_end(is_end),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_kind(tok_kind), .i_start(tok_start), .i_length(tok_length), .i_line(tok_line),
        .i_err(tok_err), .i_last(tok_last),
        .o_fail_count(fail_count), .o_pending(pending), .o_accepts(accepts)
    );

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // send one request from a falling edge, with an occasional random gap after it
    task automatic send(input logic [7:0] b, input logic fin);
        in_valid <= 1'b1;
        in_byte <= b;
        is_end <= fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        if ($urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
    endtask

    task automatic drain_and_config(input logic v);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver stall pattern with one long hold-off
    initial begin
        int phase;
        out_stall = 1'b0;
        phase = 0;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                stall_busy = 1;
                repeat (60) @(negedge clk);
                hold_off = 0;
                stall_busy = 0;
                out_stall <= 1'b0;
            end else begin
                phase++;
                if ((phase / 50) % 3 == 0) out_stall <= 1'b0;
                else out_stall <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 2000) begin
                $display("tb_script_token_scanner_core: errors");
                $finish;
            end
        end
    end

    initial begin
        int n;
        in_valid = 0; in_byte = 0; is_end = 0; cfg_we = 0; cfg_data = 0; rst_n = 0;
        hold_off = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        cfg_we <= 1'b1;
        cfg_data <= 1'b0;
        @(negedge clk);
        cfg_we <= 1'b0;

        // directed: every operator, literal forms, a keyword, errors, ends
        send_text("( ) { } [ ] ; : , - + * ^ \\ / ! != = == => < <= > >= ~ ~= ... .. .");
        send_text("\n12 3.25 7i 9.x 1. continue andx // c\n");
        send_text("@"); send(8'h00, 0); send(8'h80, 0); send(8'hFF, 0); send(8'h7F, 0);
        send_text("9."); send(0, 1);
        send_text("\"open\nstr"); send(0, 1);
        send_text("<"); send(0, 1);
        drain_and_config(1'b1);
        send_text("a.."); send(0, 1);
        send_text("x"); send(0, 1);
        send_text("/"); send(0, 1);

        hold_off = 1;
        send_text("(((((((((())))))))))a.b.c");
        while (stall_busy || hold_off) send_text("a;");
        drain_and_config(1'b0);

        // random: mostly well-formed token streams, some noise
        while (accepts < 440) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin send_text(words[$urandom_range(0, words.size()-1)]); end
                3, 4, 5: begin send_text(snippets[$urandom_range(0, snippets.size()-1)]); end
                6: send(8'($urandom_range(0, 255)), 1'b0);
                7: send_text(" ");
                8: send(8'($urandom_range(48, 57)), 1'b0);
                default: if ($urandom_range(0, 5) == 0) begin
                    send(8'($urandom), 1'b1);
                    if ($urandom_range(0, 3) == 0) drain_and_config($urandom_range(0, 1));
                end
            endcase
        end
        send(0, 1);
        drain_and_config(1'b1);
        send_text("end"); send(0, 1);

        in_valid <= 1'b0;
        n = 0;
        while (pending != 0 && n < 5000) begin @(posedge clk); n++; end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_script_token_scanner_core: clean");
        end else begin
            $display("tb_script_token_scanner_core: errors");
        end
        $finish;
    end

endmodule
